// File: rtl/mcef_pkg.sv
package mcef_pkg;

  // Width of the wrapping millisecond time base used for all elapsed-time differences.
  localparam int TIME_BITS = 32;

  localparam int STAMP_BITS = 32;
  localparam int HOLD_BITS  = 16;
  localparam int REG_COUNT  = 5;
  localparam int INDEX_BITS = $clog2(REG_COUNT);

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [HOLD_BITS-1:0]  hold_t;
  typedef logic [INDEX_BITS-1:0] reg_index_t;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_SINGLE    = 2'd1,
    KIND_VISITOR   = 2'd2,
    KIND_EMERGENCY = 2'd3
  } kind_t;

  localparam reg_index_t REG_BUTTON_HOLD    = reg_index_t'(0);
  localparam reg_index_t REG_MOTION_HOLD    = reg_index_t'(1);
  localparam reg_index_t REG_AUDIO_HOLD     = reg_index_t'(2);
  localparam reg_index_t REG_EMERGENCY_HOLD = reg_index_t'(3);
  localparam reg_index_t REG_VISITOR_COOL   = reg_index_t'(4);

  localparam hold_t BUTTON_HOLD_RESET    = hold_t'(3000);
  localparam hold_t MOTION_HOLD_RESET    = hold_t'(2000);
  localparam hold_t AUDIO_HOLD_RESET     = hold_t'(1500);
  localparam hold_t EMERGENCY_HOLD_RESET = hold_t'(5000);
  localparam hold_t VISITOR_COOL_RESET   = hold_t'(5000);

endpackage

// File: rtl/mcef_step_if.sv
interface mcef_step_if;
  import mcef_pkg::*;

  logic   valid;
  logic   ready;
  stamp_t now_ms;
  logic   button_pressed;
  logic   motion_detected;
  logic   audio_report;
  logic   emergency_report;

  modport source (
    output valid, now_ms, button_pressed, motion_detected, audio_report, emergency_report,
    input  ready
  );

  modport sink (
    input  valid, now_ms, button_pressed, motion_detected, audio_report, emergency_report,
    output ready
  );

endinterface

// File: rtl/mcef_result_if.sv
interface mcef_result_if;
  import mcef_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  event_kind;
  logic   button_on;
  logic   motion_on;
  logic   audio_on;
  logic   emergency_on;
  stamp_t stamp_ms;

  modport source (
    output valid, event_kind, button_on, motion_on, audio_on, emergency_on, stamp_ms,
    input  ready
  );

  modport sink (
    input  valid, event_kind, button_on, motion_on, audio_on, emergency_on, stamp_ms,
    output ready
  );

endinterface

// File: rtl/multi_channel_event_fusion_core.sv
// Multi-channel event fusion. Each step transfer on the step channel carries a
// millisecond timestamp, the button and motion levels and the audio and emergency
// report pulses; for each one the block returns exactly one result transfer with
// the event kind (none, single channel, visitor, emergency), the four channel
// activity flags after the step and an echo of the timestamp. Steps are taken one
// per clock cycle when the result side keeps up: a step is captured in an input
// register, the whole decision (report handling, hold-window checks, cooldown)
// is one pass of subtract-and-compare logic, and the result moves into the result
// register once that register is free. The channel state and the last visitor
// time advance on the cycle a step moves into the result register, so the next
// step always sees the state its predecessor left. A stalled result register holds the
// step in the input register; the step channel is ready whenever the input
// register is empty or moves on in the same cycle. Hold and cooldown registers
// are written through the plain write port; an index beyond the last register is
// ignored. Write them only while no step is in flight. Time differences wrap
// modulo 2^TIME_BITS.
module multi_channel_event_fusion_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write_en,
  input  mcef_pkg::reg_index_t   write_index,
  input  mcef_pkg::hold_t        write_data,
  mcef_step_if.sink              step,
  mcef_result_if.source          result
);
  import mcef_pkg::*;

  // configuration
  hold_t button_hold;
  hold_t motion_hold;
  hold_t audio_hold;
  hold_t emergency_hold;
  hold_t visitor_cool;

  // channel state
  logic  button_flag;
  time_t button_time;
  logic  motion_flag;
  time_t motion_time;
  logic  audio_flag;
  time_t audio_time;
  logic  emergency_flag;
  time_t emergency_time;
  time_t last_visitor_time;

  // input register
  logic   in_valid;
  stamp_t in_now;
  logic   in_button;
  logic   in_motion;
  logic   in_audio;
  logic   in_emergency;

  // result register
  logic   out_valid;
  kind_t  out_kind;
  logic   out_button;
  logic   out_motion;
  logic   out_audio;
  logic   out_emergency;
  stamp_t out_stamp;

  logic advance;

  time_t now;
  logic  button_flag_next;
  time_t button_time_next;
  logic  motion_flag_next;
  time_t motion_time_next;
  logic  audio_start;
  logic  audio_flag_next;
  time_t audio_time_next;
  logic  emergency_flag_next;
  time_t emergency_time_next;
  time_t last_visitor_time_next;
  time_t button_elapsed;
  time_t motion_elapsed;
  time_t audio_elapsed;
  time_t emergency_elapsed;
  time_t visitor_elapsed;
  logic  two_or_more;
  logic  exactly_one;
  kind_t kind_next;

  // Move the held step into the result register once that register is free.
  assign advance     = in_valid && (!out_valid || result.ready);
  assign step.ready  = !in_valid || advance;

  assign result.valid        = out_valid;
  assign result.event_kind   = out_kind;
  assign result.button_on    = out_button;
  assign result.motion_on    = out_motion;
  assign result.audio_on     = out_audio;
  assign result.emergency_on = out_emergency;
  assign result.stamp_ms     = out_stamp;

  // Decision pass for the step in the input register.
  always_comb begin
    now = time_t'(in_now);

    // Audio starts its window only while the stored flag is clear, stale or not.
    audio_start     = in_audio && !audio_flag;
    audio_time_next = audio_start ? now : audio_time;
    // An emergency report always restarts its window.
    emergency_time_next = in_emergency ? now : emergency_time;

    button_elapsed    = now - button_time;
    motion_elapsed    = now - motion_time;
    audio_elapsed     = now - audio_time_next;
    emergency_elapsed = now - emergency_time_next;
    visitor_elapsed   = now - last_visitor_time;

    // Button and motion: refresh on a high level, drop once past the hold.
    button_time_next = in_button ? now : button_time;
    button_flag_next = in_button ||
                       (button_flag && !(button_elapsed > time_t'(button_hold)));
    motion_time_next = in_motion ? now : motion_time;
    motion_flag_next = in_motion ||
                       (motion_flag && !(motion_elapsed > time_t'(motion_hold)));

    // Audio and emergency stay on while the elapsed time is within the hold.
    audio_flag_next     = (audio_flag || in_audio) &&
                          (audio_elapsed <= time_t'(audio_hold));
    emergency_flag_next = (emergency_flag || in_emergency) &&
                          (emergency_elapsed <= time_t'(emergency_hold));

    two_or_more = (button_flag_next && motion_flag_next) ||
                  (button_flag_next && audio_flag_next) ||
                  (motion_flag_next && audio_flag_next);
    exactly_one = (button_flag_next ^ motion_flag_next ^ audio_flag_next) && !two_or_more;

    last_visitor_time_next = last_visitor_time;
    if (emergency_flag_next) begin
      kind_next = KIND_EMERGENCY;
    end else if (two_or_more) begin
      // Raise a visitor only once per cooldown; a suppressed one reports none.
      if (visitor_elapsed >= time_t'(visitor_cool)) begin
        kind_next              = KIND_VISITOR;
        last_visitor_time_next = now;
      end else begin
        kind_next = KIND_NONE;
      end
    end else if (exactly_one) begin
      kind_next = KIND_SINGLE;
    end else begin
      kind_next = KIND_NONE;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      button_hold    <= BUTTON_HOLD_RESET;
      motion_hold    <= MOTION_HOLD_RESET;
      audio_hold     <= AUDIO_HOLD_RESET;
      emergency_hold <= EMERGENCY_HOLD_RESET;
      visitor_cool   <= VISITOR_COOL_RESET;
    end else if (write_en) begin
      unique case (write_index)
        REG_BUTTON_HOLD:    button_hold    <= write_data;
        REG_MOTION_HOLD:    motion_hold    <= write_data;
        REG_AUDIO_HOLD:     audio_hold     <= write_data;
        REG_EMERGENCY_HOLD: emergency_hold <= write_data;
        REG_VISITOR_COOL:   visitor_cool   <= write_data;
        default: ;
      endcase
    end
  end

  // Channel state advances with each step that reaches the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      button_flag       <= 1'b0;
      button_time       <= '0;
      motion_flag       <= 1'b0;
      motion_time       <= '0;
      audio_flag        <= 1'b0;
      audio_time        <= '0;
      emergency_flag    <= 1'b0;
      emergency_time    <= '0;
      last_visitor_time <= '0;
    end else if (advance) begin
      button_flag       <= button_flag_next;
      button_time       <= button_time_next;
      motion_flag       <= motion_flag_next;
      motion_time       <= motion_time_next;
      audio_flag        <= audio_flag_next;
      audio_time        <= audio_time_next;
      emergency_flag    <= emergency_flag_next;
      emergency_time    <= emergency_time_next;
      last_visitor_time <= last_visitor_time_next;
    end
  end

  // Input register: take a new step whenever the held one moves on or none is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (step.ready) begin
      in_valid <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.ready) begin
      in_now       <= step.now_ms;
      in_button    <= step.button_pressed;
      in_motion    <= step.motion_detected;
      in_audio     <= step.audio_report;
      in_emergency <= step.emergency_report;
    end
  end

  // Result register: hold while the far side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind      <= kind_next;
      out_button    <= button_flag_next;
      out_motion    <= motion_flag_next;
      out_audio     <= audio_flag_next;
      out_emergency <= emergency_flag_next;
      out_stamp     <= in_now;
    end
  end

endmodule
